>>> hw/rtl/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse block.
// Depends on nothing; mi3_div, the top, the checker and the testbench import it.
package mi3_pkg;

    localparam int IO_W           = 32;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int N_ELEM         = 9;

    // Element indexes (row * 3 + column) of x, y, z, w for cofactor x*y - z*w.
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 3, 1}
    };

    typedef struct packed {
        logic [IO_W-1:0] q;
        logic            sat;
        logic            sing;
    } lane_res_t;

endpackage

>>> hw/rtl/mi3_cof.sv
// One cofactor lane: two registered products and their registered difference.
// Depends on nothing outside this file.
module mi3_cof #(
    parameter int DW = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [DW-1:0] x,
    input  logic signed [DW-1:0] y,
    input  logic signed [DW-1:0] z,
    input  logic signed [DW-1:0] w,
    output logic signed [2*DW:0] c
);
    logic signed [2*DW-1:0] p1_reg, p2_reg;
    logic signed [2*DW:0]   c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= x * y;
            p2_reg <= z * w;
            c_reg  <= (2*DW+1)'(p1_reg) - (2*DW+1)'(p2_reg);
        end
    end

    assign c = c_reg;
endmodule

>>> hw/rtl/mi3_det.sv
// Determinant by first-row expansion: split partial products, then one sum.
// Depends on nothing outside this file.
module mi3_det #(
    parameter int DW = 32
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [DW-1:0]   a [3],
    input  logic signed [2*DW:0]   c [3],
    output logic signed [3*DW+2:0] det
);
    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;

    logic signed [2*DW:0]   pl_reg [3];
    logic signed [2*DW:0]   ph_reg [3];
    logic signed [DETW-1:0] t [3];
    logic signed [DETW-1:0] det_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_pp
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pl_reg[k] <= a[k] * $signed({1'b0, c[k][DW-1:0]});
                ph_reg[k] <= a[k] * $signed(c[k][CW-1:DW]);
            end
        end
        assign t[k] = (DETW'(ph_reg[k]) <<< DW) + DETW'(pl_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= t[0] + t[1] + t[2];
        end
    end

    assign det = det_reg;
endmodule

>>> hw/rtl/mi3_div.sv
// One division lane: magnitudes, a restoring divider with one quotient bit
// per stage, then saturation and sign. Depends on mi3_pkg.
module mi3_div #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [2*DW:0]   c,
    input  logic signed [3*DW+2:0] det,
    output mi3_pkg::lane_res_t     res
);
    import mi3_pkg::*;

    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int NW   = CW + 2 * FB;
    localparam int RW   = ((NW > DETW + DW) ? NW : DETW + DW) + 1;

    logic [RW-1:0] r_reg   [DW+1];
    logic [RW-1:0] d_reg   [DW+1];
    logic [DW-1:0] q_reg   [DW+1];
    logic          neg_reg [DW+1];
    logic          ovf_reg [DW+1];
    logic          sing_reg[DW+1];

    logic [CW-1:0]   cm;
    logic [DETW-1:0] dm;
    logic [RW-1:0]   n_full, d_full;

    assign cm     = c[CW-1] ? CW'(-c) : CW'(c);
    assign dm     = det[DETW-1] ? DETW'(-det) : DETW'(det);
    assign n_full = RW'(cm) << (2 * FB);
    assign d_full = RW'(dm);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= n_full;
            d_reg[0]    <= d_full;
            q_reg[0]    <= '0;
            neg_reg[0]  <= c[CW-1] ^ det[DETW-1];
            ovf_reg[0]  <= n_full >= (d_full << DW);
            sing_reg[0] <= (det == '0);
        end
    end

    for (genvar s = 0; s < DW; s++)
    begin : g_step
        localparam int BIT = DW - 1 - s;
        logic [RW:0] trial;
        assign trial = {1'b0, r_reg[s]} - ({1'b0, d_reg[s]} << BIT);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s+1]    <= trial[RW] ? r_reg[s] : trial[RW-1:0];
                q_reg[s+1]    <= q_reg[s] | (trial[RW] ? DW'(0) : (DW'(1) << BIT));
                d_reg[s+1]    <= d_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                ovf_reg[s+1]  <= ovf_reg[s];
                sing_reg[s+1] <= sing_reg[s];
            end
        end
    end

    logic [DW-1:0]        lim, qs, qv;
    logic signed [DW-1:0] vs;
    logic                 clip;
    lane_res_t            res_next, res_reg;

    always_comb
    begin
        lim  = (DW'(1) << (DW - 1)) - (neg_reg[DW] ? DW'(0) : DW'(1));
        qv   = q_reg[DW];
        clip = ovf_reg[DW] || (qv > lim);
        qs   = clip ? lim : qv;
        vs   = neg_reg[DW] ? $signed(-qs) : $signed(qs);
        res_next.q    = sing_reg[DW] ? '0 : IO_W'(vs);
        res_next.sat  = clip && !sing_reg[DW];
        res_next.sing = sing_reg[DW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;
endmodule

>>> hw/rtl/matrix_inverse_3x3.sv
// Throughput: one word per cycle while the output is not stalled; the
// whole pipeline advances together.
// The divider depth (one quotient bit per stage) sets the latency.
// Reset (rst_n, asynchronous, active low) clears the valid pipeline only.
// 3x3 matrix inverse by adjugate; depends on mi3_pkg, mi3_cof, mi3_det, mi3_div.
module matrix_inverse_3x3
    #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [mi3_pkg::IO_W-1:0]  m_r0_c0,
    input  logic [mi3_pkg::IO_W-1:0]  m_r0_c1,
    input  logic [mi3_pkg::IO_W-1:0]  m_r0_c2,
    input  logic [mi3_pkg::IO_W-1:0]  m_r1_c0,
    input  logic [mi3_pkg::IO_W-1:0]  m_r1_c1,
    input  logic [mi3_pkg::IO_W-1:0]  m_r1_c2,
    input  logic [mi3_pkg::IO_W-1:0]  m_r2_c0,
    input  logic [mi3_pkg::IO_W-1:0]  m_r2_c1,
    input  logic [mi3_pkg::IO_W-1:0]  m_r2_c2,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [mi3_pkg::IO_W-1:0]  inv_r0_c0,
    output logic [mi3_pkg::IO_W-1:0]  inv_r0_c1,
    output logic [mi3_pkg::IO_W-1:0]  inv_r0_c2,
    output logic [mi3_pkg::IO_W-1:0]  inv_r1_c0,
    output logic [mi3_pkg::IO_W-1:0]  inv_r1_c1,
    output logic [mi3_pkg::IO_W-1:0]  inv_r1_c2,
    output logic [mi3_pkg::IO_W-1:0]  inv_r2_c0,
    output logic [mi3_pkg::IO_W-1:0]  inv_r2_c1,
    output logic [mi3_pkg::IO_W-1:0]  inv_r2_c2,
    output logic                      singular,
    output logic                      saturated
);
    import mi3_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int LAT  = DW + 7;

    // The pipeline moves as one: it advances unless a finished word is held
    // at the output by a stall from downstream.
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    logic [LAT-1:0] vld_reg, vld_next;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Elements use the low DATA_WIDTH bits of each field as a signed value.
    logic [IO_W-1:0]      m_raw [N_ELEM];
    logic signed [DW-1:0] a [N_ELEM];

    assign m_raw = '{m_r0_c0, m_r0_c1, m_r0_c2, m_r1_c0, m_r1_c1, m_r1_c2,
                     m_r2_c0, m_r2_c1, m_r2_c2};

    for (genvar k = 0; k < N_ELEM; k++)
    begin : g_elem
        assign a[k] = $signed(m_raw[k][DW-1:0]);
    end

    // Nine cofactor lanes work side by side on the same matrix.
    logic signed [CW-1:0] c [N_ELEM];

    for (genvar k = 0; k < N_ELEM; k++)
    begin : g_cof
        mi3_cof #(.DW(DW)) u_cof (
            .clk (clk),
            .en  (en),
            .x   (a[COF_IDX[k][0]]),
            .y   (a[COF_IDX[k][1]]),
            .z   (a[COF_IDX[k][2]]),
            .w   (a[COF_IDX[k][3]]),
            .c   (c[k])
        );
    end

    // First-row elements wait two stages so they meet their cofactors.
    logic signed [DW-1:0] a_d1_reg [3];
    logic signed [DW-1:0] a_d2_reg [3];
    logic signed [CW-1:0] c_d1_reg [N_ELEM];
    logic signed [CW-1:0] c_d2_reg [N_ELEM];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_d1_reg[k] <= a[k];
                a_d2_reg[k] <= a_d1_reg[k];
            end
            for (int k = 0; k < N_ELEM; k++)
            begin
                c_d1_reg[k] <= c[k];
                c_d2_reg[k] <= c_d1_reg[k];
            end
        end
    end

    logic signed [CW-1:0]   c_row [3];
    logic signed [DETW-1:0] det;

    assign c_row = '{c[0], c[3], c[6]};

    mi3_det #(.DW(DW)) u_det (
        .clk (clk),
        .en  (en),
        .a   (a_d2_reg),
        .c   (c_row),
        .det (det)
    );

    // Nine division lanes, each dividing one delayed cofactor by the determinant.
    lane_res_t res [N_ELEM];

    for (genvar k = 0; k < N_ELEM; k++)
    begin : g_div
        mi3_div #(.DW(DW), .FB(FRAC_BITS)) u_div (
            .clk (clk),
            .en  (en),
            .c   (c_d2_reg[k]),
            .det (det),
            .res (res[k])
        );
    end

    // Merging stage: collects the lanes into the output word and ORs the
    // per-lane clip flags. The singular flag is the same in every lane.
    logic [IO_W-1:0] inv_reg [N_ELEM];
    logic            sing_reg, sat_reg;
    logic            sat_any;

    always_comb
    begin
        sat_any = 1'b0;
        for (int k = 0; k < N_ELEM; k++)
        begin
            sat_any = sat_any | res[k].sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                inv_reg[k] <= res[k].q;
            end
            sing_reg <= res[0].sing;
            sat_reg  <= sat_any;
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign inv_r0_c0 = inv_reg[0];
    assign inv_r0_c1 = inv_reg[1];
    assign inv_r0_c2 = inv_reg[2];
    assign inv_r1_c0 = inv_reg[3];
    assign inv_r1_c1 = inv_reg[4];
    assign inv_r1_c2 = inv_reg[5];
    assign inv_r2_c0 = inv_reg[6];
    assign inv_r2_c1 = inv_reg[7];
    assign inv_r2_c2 = inv_reg[8];
    assign singular  = sing_reg;
    assign saturated = sat_reg;
endmodule

>>> hw/rtl/mi3_checker.sv
// Port-level assertions for the 3x3 matrix inverse, and the bind to its top.
// Depends on mi3_pkg and matrix_inverse_3x3.
module mi3_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [mi3_pkg::IO_W-1:0] inv_r0_c0,
    input logic [mi3_pkg::IO_W-1:0] inv_r2_c2,
    input logic                     singular,
    input logic                     saturated
);
    import mi3_pkg::*;

    a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> !saturated)
        else $error("singular word also flags saturation");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> inv_r0_c0 == '0 && inv_r2_c2 == '0)
        else $error("singular word carries nonzero elements");

    a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the held output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(inv_r0_c0) && $stable(saturated))
        else $error("stalled output word changed");
endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .inv_r0_c0 (inv_r0_c0),
    .inv_r2_c2 (inv_r2_c2),
    .singular  (singular),
    .saturated (saturated)
);

>>> tb/sv/matrix_inverse_3x3_test.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse block.
// Depends on mi3_pkg and matrix_inverse_3x3 from the RTL.
`timescale 1ns / 100ps

module matrix_inverse_3x3_test;

    import mi3_pkg::*;

    localparam int DW         = DATA_WIDTH_DEF;
    localparam int FB         = FRAC_BITS_DEF;
    localparam int LATENCY    = DW + 7;
    localparam int N_RANDOM   = 1150;
    localparam int STALL_MAX  = 20000;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    // Kind of a directed table row: either the exact answer is typed in,
    // or the row is checked against the predictor.
    typedef enum logic [1:0] {ROW_PREDICT, ROW_EXACT} row_kind_t;

    typedef struct {
        logic [31:0] elem [N_ELEM];
    } matrix_t;

    typedef struct {
        logic [31:0] elem [N_ELEM];
        logic        singular;
        logic        saturated;
    } inverse_t;

    typedef struct {
        row_kind_t kind;
        matrix_t   m;
        inverse_t  inv;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] m_in [N_ELEM];
    logic        out_valid;
    logic        out_stall;
    logic [31:0] inv_out [N_ELEM];
    logic        singular;
    logic        saturated;

    inverse_t    pending_inverses [$];
    int          error_count;
    int          words_sent;
    int          words_checked;
    int          singular_seen;
    int          saturated_seen;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    matrix_inverse_3x3 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .m_r0_c0   (m_in[0]),
        .m_r0_c1   (m_in[1]),
        .m_r0_c2   (m_in[2]),
        .m_r1_c0   (m_in[3]),
        .m_r1_c1   (m_in[4]),
        .m_r1_c2   (m_in[5]),
        .m_r2_c0   (m_in[6]),
        .m_r2_c1   (m_in[7]),
        .m_r2_c2   (m_in[8]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .inv_r0_c0 (inv_out[0]),
        .inv_r0_c1 (inv_out[1]),
        .inv_r0_c2 (inv_out[2]),
        .inv_r1_c0 (inv_out[3]),
        .inv_r1_c1 (inv_out[4]),
        .inv_r1_c2 (inv_out[5]),
        .inv_r2_c0 (inv_out[6]),
        .inv_r2_c1 (inv_out[7]),
        .inv_r2_c2 (inv_out[8]),
        .singular  (singular),
        .saturated (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Computes the inverse by adjugate exactly. Cofactors need at most 65
    // signed bits and the determinant 99, so 130-bit signed math never wraps.
    // Each quotient is truncated toward zero and then clipped to DW bits.
    function automatic inverse_t compute_inverse(matrix_t m);
        logic signed [129:0] a [N_ELEM];
        logic signed [129:0] cof [N_ELEM];
        logic signed [129:0] det;
        logic signed [129:0] quo;
        logic signed [129:0] hi_lim;
        logic signed [129:0] lo_lim;
        inverse_t r;
        hi_lim = (130'sd1 <<< (DW - 1)) - 130'sd1;
        lo_lim = -(130'sd1 <<< (DW - 1));
        for (int i = 0; i < N_ELEM; i++)
            a[i] = $signed(m.elem[i][DW-1:0]);
        for (int i = 0; i < N_ELEM; i++)
            cof[i] = a[COF_IDX[i][0]] * a[COF_IDX[i][1]]
                   - a[COF_IDX[i][2]] * a[COF_IDX[i][3]];
        det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
        r.singular  = (det == 0);
        r.saturated = 1'b0;
        for (int i = 0; i < N_ELEM; i++)
        begin
            if (det == 0)
            begin
                r.elem[i] = '0;
                continue;
            end
            // SystemVerilog signed division already truncates toward zero.
            quo = (cof[i] <<< (2 * FB)) / det;
            if (quo > hi_lim)
            begin
                quo = hi_lim;
                r.saturated = 1'b1;
            end
            else if (quo < lo_lim)
            begin
                quo = lo_lim;
                r.saturated = 1'b1;
            end
            r.elem[i] = quo[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] random_element();
        case ($urandom_range(0, 9))
            0:       return MAXV;
            1:       return MINV;
            2:       return 32'($signed($urandom_range(0, 8)) - 4) <<< FB;
            3:       return $urandom_range(0, 15);
            4, 5:    return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            default: return $urandom();
        endcase
    endfunction

    // Random matrices, some with a raised diagonal and some rank-deficient ones with a
    // repeated row or a zero column so the singular path is exercised.
    function automatic matrix_t random_matrix();
        matrix_t m;
        int pick;
        for (int i = 0; i < N_ELEM; i++)
            m.elem[i] = random_element();
        pick = $urandom_range(0, 9);
        if (pick == 0)
            for (int c = 0; c < 3; c++)
                m.elem[3 + c] = m.elem[c];
        else if (pick == 1)
            for (int r = 0; r < 3; r++)
                m.elem[3 * r + 2] = '0;
        else if (pick < 5)
            for (int d = 0; d < 3; d++)
                m.elem[4 * d] = m.elem[4 * d] + (32'($urandom_range(1, 64)) <<< FB);
        return m;
    endfunction

    function automatic matrix_t diag_matrix(logic [31:0] d0, logic [31:0] d1,
                                            logic [31:0] d2);
        matrix_t m;
        for (int i = 0; i < N_ELEM; i++)
            m.elem[i] = '0;
        m.elem[0] = d0;
        m.elem[4] = d1;
        m.elem[8] = d2;
        return m;
    endfunction

    function automatic inverse_t diag_inverse(logic [31:0] d, logic sing, logic sat);
        inverse_t r;
        for (int i = 0; i < N_ELEM; i++)
            r.elem[i] = '0;
        r.elem[0]   = d;
        r.elem[4]   = d;
        r.elem[8]   = d;
        r.singular  = sing;
        r.saturated = sat;
        return r;
    endfunction

    // Sends one matrix: valid is raised at a falling edge and held, with the
    // payload steady, until a rising edge sees it accepted. Valid stays high
    // into the next falling edge; the next send or an idle cycle decides it.
    task automatic send_matrix(matrix_t m, inverse_t expected);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < N_ELEM; i++)
            m_in[i] <= m.elem[i];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_inverses.push_back(expected);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_inverses.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: stall is chosen at each falling edge, results are checked at
    // the rising edge where they are accepted.
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_inverses.size() == 0)
            begin
                $error("Result word with no matrix outstanding");
                error_count++;
            end
            else
            begin
                inverse_t e;
                e = pending_inverses.pop_front();
                for (int i = 0; i < N_ELEM; i++)
                    if (inv_out[i] !== e.elem[i])
                    begin
                        $error("inv_r%0d_c%0d: expected %h, got %h",
                               i / 3, i % 3, e.elem[i], inv_out[i]);
                        error_count++;
                    end
                if (singular !== e.singular)
                begin
                    $error("singular: expected %b, got %b", e.singular, singular);
                    error_count++;
                end
                if (saturated !== e.saturated)
                begin
                    $error("saturated: expected %b, got %b", e.saturated, saturated);
                    error_count++;
                end
                singular_seen  += singular;
                saturated_seen += saturated;
                words_checked++;
            end
        end
    end

    // Watchdog: any cycle with no handshake on either side counts toward
    // the limit, which is far above the slowest stall run we generate.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        matrix_t   m;

        error_count    = 0;
        words_sent     = 0;
        words_checked  = 0;
        singular_seen  = 0;
        saturated_seen = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        for (int i = 0; i < N_ELEM; i++)
            m_in[i] = '0;

        // Directed rows. Exact answers: identity, zero matrix, a tiny
        // diagonal whose inverse clips high, and a tiny negative one that
        // clips low. Others go through the predictor.
        row.kind = ROW_EXACT;
        row.m = diag_matrix(ONE, ONE, ONE);
        row.inv = diag_inverse(ONE, 1'b0, 1'b0);
        rows.push_back(row);
        row.m = diag_matrix('0, '0, '0);
        row.inv = diag_inverse('0, 1'b1, 1'b0);
        rows.push_back(row);
        row.m = diag_matrix(32'd1, 32'd1, 32'd1);
        row.inv = diag_inverse(MAXV, 1'b0, 1'b1);
        rows.push_back(row);
        row.m = diag_matrix(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        row.inv = diag_inverse(MINV, 1'b0, 1'b1);
        rows.push_back(row);
        row.kind = ROW_PREDICT;
        row.m = diag_matrix(MAXV, MAXV, MAXV);
        rows.push_back(row);
        row.m = diag_matrix(MINV, MINV, MINV);
        rows.push_back(row);
        row.m = diag_matrix(MINV, MAXV, 32'hfffe_0000);
        rows.push_back(row);
        for (int i = 0; i < N_ELEM; i++)
            m.elem[i] = MAXV;
        row.m = m;
        rows.push_back(row);
        for (int i = 0; i < N_ELEM; i++)
            m.elem[i] = (i % 2) ? MINV : MAXV;
        row.m = m;
        rows.push_back(row);
        for (int i = 0; i < N_ELEM; i++)
            m.elem[i] = 32'(i + 1) <<< FB;
        row.m = m;
        rows.push_back(row);
        m.elem[8] = 32'd10 <<< FB;
        row.m = m;
        rows.push_back(row);
        for (int k = 0; k < 8; k++)
        begin
            row.m = random_matrix();
            rows.push_back(row);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_matrix(rows[i].m, (rows[i].kind == ROW_EXACT) ? rows[i].inv
                                                               : compute_inverse(rows[i].m));
        // Let the pipeline empty before the random phases begin.
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 45 : 0;
            recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 28 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++)
            begin
                m = random_matrix();
                send_matrix(m, compute_inverse(m));
                if (k == N_RANDOM / 6)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (LATENCY + 10) @(negedge clk);

        $display("Sent %0d matrices and checked %0d inverses.", words_sent, words_checked);
        $display("Singular inputs seen: %0d, clipped results seen: %0d.",
                 singular_seen, saturated_seen);
        if (error_count == 0 && pending_inverses.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_cof.sv
hw/rtl/mi3_det.sv
hw/rtl/mi3_div.sv
hw/rtl/matrix_inverse_3x3.sv
hw/rtl/mi3_checker.sv
tb/sv/matrix_inverse_3x3_test.sv
